>>> hdl/greedy_change_maker_assert.svh
// assertion macros for the greedy change maker
`ifndef GREEDY_CHANGE_MAKER_ASSERT_SVH
`define GREEDY_CHANGE_MAKER_ASSERT_SVH

// condition holds at every edge out of reset
`define GCM_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GCM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hdl/gcm_pkg.sv
// shared constants, types and codes of the greedy change maker
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

   localparam int NUM_SLOTS  = 4;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CFG_SLOTS  = 4;
   localparam int COUNT_W    = 3;
   localparam int VALUE_W    = 16;
   localparam int AMOUNT_W   = 16;
   localparam int SLOT_IN_W  = 2;
   localparam int STOCK_W    = 8;
   localparam int BIT_W      = $clog2(STOCK_W);
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DENOM_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DENOM_VALUE = 3'd1;

   localparam logic OP_CHANGE = 1'b0;
   localparam logic OP_SET    = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0]                denom_count;
      logic [NUM_SLOTS-1:0][VALUE_W-1:0] denom_value;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT,
      ST_STEP,
      ST_OUT
   } state_type;

   function automatic logic [VALUE_W-1:0] denom_reset(input int s);
      logic [VALUE_W-1:0] v;
      unique case (s)
         0: v = 16'd1;
         1: v = 16'd2;
         2: v = 16'd5;
         3: v = 16'd10;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/gcm_cfg.sv
// configuration registers: active slot count and denomination values
`timescale 1ns / 1ps
`default_nettype none

module gcm_cfg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [gcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gcm_pkg::VALUE_W-1:0]   csr_wdata,
   output gcm_pkg::cfg_type                   cfg
);
   import gcm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_index == CSR_DENOM_COUNT) begin
            cfg_in.denom_count = csr_wdata[COUNT_W-1:0];
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (s < CFG_SLOTS && csr_index == CSR_DENOM_VALUE + CSR_IDX_W'(s)) begin
               cfg_in.denom_value[s] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.denom_count <= COUNT_RESET;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            cfg_ff.denom_value[s] <= denom_reset(s);
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/gcm_unit.sv
// shift-subtract step: tries one bit of the coin count against amount and stock
`timescale 1ns / 1ps
`default_nettype none

module gcm_unit (
   input  wire logic [gcm_pkg::VALUE_W-1:0]  denom,
   input  wire logic [gcm_pkg::AMOUNT_W-1:0] rem,
   input  wire logic [gcm_pkg::STOCK_W-1:0]  take,
   input  wire logic [gcm_pkg::STOCK_W-1:0]  stock,
   input  wire logic [gcm_pkg::BIT_W-1:0]    bit_pos,
   output logic      [gcm_pkg::STOCK_W-1:0]  take_next,
   output logic      [gcm_pkg::AMOUNT_W-1:0] rem_next
);
   import gcm_pkg::*;

   localparam int WIDE_W = VALUE_W + STOCK_W;

   logic [WIDE_W-1:0]  denom_shift;
   logic [WIDE_W-1:0]  rem_wide;
   logic [STOCK_W-1:0] trial;
   logic               fits;

   always_comb begin
      denom_shift = WIDE_W'(denom) << bit_pos;
      rem_wide    = WIDE_W'(rem);
      trial       = take | (STOCK_W'(1) << bit_pos);
      fits        = (denom_shift <= rem_wide) && (trial <= stock);
      take_next   = fits ? trial : take;
      rem_next    = fits ? (rem - denom_shift[AMOUNT_W-1:0]) : rem;
   end

endmodule

`default_nettype wire

>>> hdl/greedy_change_maker.sv
// greedy change maker top level: sequencer, coin stock and result port
//
// req channel: one word per request. tuser carries op: set stock (1) or make change (0).
// A set-stock word updates the slot's coin count in the cycle it is accepted and
// gives no result. A change word pays out its amount from the highest active slot
// down, then returns one rsp word per active slot, slot 0 first, tlast on the
// highest. tuser on rsp is the success flag, equal on all words of a request.
// Each paying slot is worked by the one shift-subtract unit, one coin-count bit per
// cycle: each slot passes the slot state, and a paying slot then the step state
// once per coin-count bit; the results follow in the output state. req_tready is
// low from a change request until its last rsp word is taken; a stall on rsp holds
// the current word.
// Reset restores the denominations 1, 2, 5, 10 with four active slots and empties
// every coin stock. The csr port writes a register; the user must write it only while idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_change_maker_assert.svh"

module greedy_change_maker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [gcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gcm_pkg::VALUE_W-1:0]    csr_wdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // amount [15:0], slot [17:16], stock_value [25:18]
   input  wire logic [gcm_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // slot_out [1:0], coins_used [9:2]
   output logic      [gcm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // success
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import gcm_pkg::*;

   cfg_type cfg;

   state_type           state_ff, state_in;
   logic [AMOUNT_W-1:0] rem_ff, rem_in;
   logic [SLOT_W-1:0]   slot_idx_ff, slot_idx_in;
   logic [SLOT_W-1:0]   last_idx_ff, last_idx_in;
   logic [SLOT_W-1:0]   out_idx_ff, out_idx_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [STOCK_W-1:0]  take_ff, take_in;
   logic [STOCK_W-1:0]  stock_ff [NUM_SLOTS];
   logic [STOCK_W-1:0]  stock_in [NUM_SLOTS];
   logic [STOCK_W-1:0]  used_ff [NUM_SLOTS];
   logic [STOCK_W-1:0]  used_in [NUM_SLOTS];

   logic [AMOUNT_W-1:0]  req_amount;
   logic [SLOT_IN_W-1:0] req_slot;
   logic [STOCK_W-1:0]   req_stock;
   logic [VALUE_W-1:0]   cur_denom;
   logic [STOCK_W-1:0]   take_next;
   logic [AMOUNT_W-1:0]  rem_next;
   logic [COUNT_W-1:0]   active_count;

   assign req_amount = req_tdata[AMOUNT_W-1:0];
   assign req_slot   = req_tdata[AMOUNT_W+SLOT_IN_W-1:AMOUNT_W];
   assign req_stock  = req_tdata[AMOUNT_W+SLOT_IN_W+STOCK_W-1:AMOUNT_W+SLOT_IN_W];
   assign cur_denom  = cfg.denom_value[slot_idx_ff];

   gcm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcm_unit u_unit (
      .denom     (cur_denom),
      .rem       (rem_ff),
      .take      (take_ff),
      .stock     (stock_ff[slot_idx_ff]),
      .bit_pos   (bit_ff),
      .take_next (take_next),
      .rem_next  (rem_next)
   );

   always_comb begin
      priority if (int'(cfg.denom_count) > NUM_SLOTS) begin
         active_count = COUNT_W'(NUM_SLOTS);
      end else if (cfg.denom_count == '0) begin
         active_count = COUNT_W'(1);
      end else begin
         active_count = cfg.denom_count;
      end
   end

   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      slot_idx_in = slot_idx_ff;
      last_idx_in = last_idx_ff;
      out_idx_in  = out_idx_ff;
      bit_in      = bit_ff;
      take_in     = take_ff;
      stock_in    = stock_ff;
      used_in     = used_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_SET) begin
                  if (int'(req_slot) < NUM_SLOTS) begin
                     stock_in[SLOT_W'(req_slot)] = req_stock;
                  end
               end else begin
                  rem_in      = req_amount;
                  last_idx_in = SLOT_W'(active_count - COUNT_W'(1));
                  slot_idx_in = SLOT_W'(active_count - COUNT_W'(1));
                  for (int s = 0; s < NUM_SLOTS; s++) begin
                     used_in[s] = '0;
                  end
                  state_in = ST_SLOT;
               end
            end
         end
         ST_SLOT: begin
            if (cur_denom == '0 || rem_ff == '0) begin
               if (slot_idx_ff == '0) begin
                  out_idx_in = '0;
                  state_in   = ST_OUT;
               end else begin
                  slot_idx_in = slot_idx_ff - SLOT_W'(1);
               end
            end else begin
               bit_in   = BIT_W'(STOCK_W - 1);
               take_in  = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            take_in = take_next;
            rem_in  = rem_next;
            bit_in  = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               stock_in[slot_idx_ff] = stock_ff[slot_idx_ff] - take_next;
               used_in[slot_idx_ff]  = take_next;
               if (slot_idx_ff == '0) begin
                  out_idx_in = '0;
                  state_in   = ST_OUT;
               end else begin
                  slot_idx_in = slot_idx_ff - SLOT_W'(1);
                  state_in    = ST_SLOT;
               end
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (out_idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            stock_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         stock_ff <= stock_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      slot_idx_ff <= slot_idx_in;
      last_idx_ff <= last_idx_in;
      out_idx_ff  <= out_idx_in;
      bit_ff      <= bit_in;
      take_ff     <= take_in;
      used_ff     <= used_in;
   end

   assign rsp_tdata = RSP_DATA_W'({used_ff[out_idx_ff], SLOT_IN_W'(out_idx_ff)});
   assign rsp_tuser = (rem_ff == '0);
   assign rsp_tlast = (out_idx_ff == last_idx_ff);

   `GCM_ASSERT(a_req_rsp_excl, !(req_tready && rsp_tvalid), "req and rsp open together")
   `GCM_ASSERT(a_take_in_stock, (state_ff != ST_STEP) || (take_ff <= stock_ff[slot_idx_ff]), "coin count above stock")
   `GCM_ASSERT_NEXT(a_last_frees, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "not ready after last word")
   `GCM_ASSERT_NEXT(a_flag_steady, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tuser == $past(rsp_tuser)), "success flag changed within request")

endmodule

`default_nettype wire

>>> verif/tb_greedy_change_maker.sv
// self-checking testbench for the greedy change maker: directed and random stock and change words
`timescale 1ns / 1ps
`default_nettype none

module tb_greedy_change_maker;
   import gcm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_DENOM_VALUE + CSR_IDX_W'(CFG_SLOTS);

   typedef struct {
      logic [SLOT_W-1:0]  slot_out;
      logic [STOCK_W-1:0] coins_used;
      logic               success;
      logic               last;
   } payout_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VALUE_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   // model state
   logic [COUNT_W-1:0] count_model;
   logic [VALUE_W-1:0] denom_model [CFG_SLOTS];
   logic [STOCK_W-1:0] stock_left [NUM_SLOTS];
   payout_word_type payout_q [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int words_checked = 0;
   int change_count = 0;
   int stock_count = 0;
   int config_count = 0;

   greedy_change_maker DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void predict_payout(input logic [AMOUNT_W-1:0] amount);
      int unsigned remaining;
      int unsigned take;
      int unsigned d;
      int k;
      logic [STOCK_W-1:0] paid [NUM_SLOTS];
      payout_word_type w;
      k = count_model;
      if (k > NUM_SLOTS) k = NUM_SLOTS;
      if (k == 0) k = 1;
      remaining = amount;
      for (int s = 0; s < NUM_SLOTS; s++) paid[s] = '0;
      for (int s = k - 1; s >= 0; s--) begin
         d = denom_model[s];
         if (d == 0 || remaining == 0) continue;
         take = remaining / d;
         if (take > stock_left[s]) take = stock_left[s];
         remaining -= take * d;
         stock_left[s] = stock_left[s] - STOCK_W'(take);
         paid[s] = STOCK_W'(take);
      end
      for (int s = 0; s < k; s++) begin
         w.slot_out = SLOT_W'(s);
         w.coins_used = paid[s];
         w.success = (remaining == 0);
         w.last = (s == k - 1);
         payout_q.push_back(w);
      end
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      int unsigned acc;
      int unsigned n;
      int unsigned cap;
      int unsigned mode;
      int k;
      acc = 0;
      mode = $urandom_range(9);
      k = count_model;
      if (k > NUM_SLOTS) k = NUM_SLOTS;
      if (k == 0) k = 1;
      if (mode < 6) begin
         for (int s = 0; s < k; s++) begin
            cap = (stock_left[s] < 6) ? stock_left[s] : 6;
            n = $urandom_range(0, cap);
            if (acc + n * denom_model[s] <= 65535) acc += n * denom_model[s];
         end
         if ($urandom_range(4) == 0 && acc < 65533) acc += $urandom_range(1, 3);
      end else if (mode < 8) begin
         acc = $urandom_range(0, 200);
      end else begin
         acc = $urandom_range(0, 65535);
      end
      return acc[AMOUNT_W-1:0];
   endfunction

   task automatic send_word(input logic op, input logic [AMOUNT_W-1:0] amount,
                            input logic [SLOT_IN_W-1:0] slot,
                            input logic [STOCK_W-1:0] stock_value);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[15:0] = amount;
      word[17:16] = slot;
      word[25:18] = stock_value;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      if (op == OP_SET) begin
         if (slot < NUM_SLOTS) stock_left[slot] = stock_value;
         stock_count++;
      end else begin
         predict_payout(amount);
         change_count++;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (payout_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_denoms(input logic [COUNT_W-1:0] count,
                              input logic [VALUE_W-1:0] v0, input logic [VALUE_W-1:0] v1,
                              input logic [VALUE_W-1:0] v2, input logic [VALUE_W-1:0] v3);
      logic [VALUE_W-1:0] vals [CFG_SLOTS];
      logic [VALUE_W-1:0] count_word;
      vals = '{v0, v1, v2, v3};
      wait_idle();
      count_word = VALUE_W'($urandom_range(0, 65535));
      count_word[COUNT_W-1:0] = count;
      csr_we <= 1'b1;
      csr_index <= CSR_DENOM_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      count_model = count;
      for (int s = 0; s < CFG_SLOTS; s++) begin
         csr_index <= CSR_DENOM_VALUE + CSR_IDX_W'(s);
         csr_wdata <= vals[s];
         @(posedge clock);
         denom_model[s] = vals[s];
      end
      // writes past the last register change nothing
      csr_index <= CSR_UNUSED + CSR_IDX_W'($urandom_range(0, 2));
      csr_wdata <= VALUE_W'($urandom_range(0, 65535));
      @(posedge clock);
      csr_we <= 1'b0;
      config_count++;
   endtask

   task automatic load_random_denoms(input int count_lo, input int count_hi);
      logic [VALUE_W-1:0] v [CFG_SLOTS];
      int unsigned nxt;
      v[0] = VALUE_W'($urandom_range(1, 5));
      for (int s = 1; s < CFG_SLOTS; s++) begin
         nxt = v[s-1] + $urandom_range(1, 2 * v[s-1] + 3);
         v[s] = (nxt > 65535) ? 16'hffff : VALUE_W'(nxt);
      end
      load_denoms(COUNT_W'($urandom_range(count_lo, count_hi)), v[0], v[1], v[2], v[3]);
   endtask

   task automatic test_empty_stock();
      send_word(OP_CHANGE, 16'd0, 2'd3, 8'hff);
      send_word(OP_CHANGE, 16'd7, 2'd0, 8'h00);
   endtask

   task automatic test_stock_extremes();
      send_word(OP_SET, 16'hffff, 2'd0, 8'd255);
      send_word(OP_SET, 16'h0000, 2'd1, 8'd3);
      send_word(OP_SET, 16'h5a5a, 2'd2, 8'd1);
      send_word(OP_SET, 16'ha5a5, 2'd3, 8'd255);
      send_word(OP_CHANGE, 16'd37, 2'd1, 8'h55);
      send_word(OP_CHANGE, 16'hffff, 2'd2, 8'haa);
      send_word(OP_SET, 16'd0, 2'd2, 8'd0);
      send_word(OP_CHANGE, 16'd0, 2'd0, 8'd0);
   endtask

   task automatic test_count_and_values();
      // count of zero acts as one slot
      load_denoms(3'd0, 16'd1, 16'd2, 16'd5, 16'd10);
      send_word(OP_SET, 16'd0, 2'd0, 8'd10);
      send_word(OP_CHANGE, 16'd4, 2'd0, 8'd0);
      // count above the slot count
      load_denoms(3'd7, 16'd1, 16'd2, 16'd5, 16'd10);
      send_word(OP_SET, 16'd0, 2'd3, 8'd2);
      send_word(OP_CHANGE, 16'd13, 2'd0, 8'd0);
      // zero-valued slot keeps its stock
      load_denoms(3'd4, 16'd1, 16'd2, 16'd0, 16'd10);
      send_word(OP_SET, 16'd0, 2'd2, 8'd5);
      send_word(OP_CHANGE, 16'd23, 2'd0, 8'd0);
      // descending values still run from the top slot down
      load_denoms(3'd4, 16'd10, 16'd5, 16'd2, 16'd1);
      send_word(OP_SET, 16'd0, 2'd1, 8'd3);
      send_word(OP_CHANGE, 16'd17, 2'd0, 8'd0);
      // single slot with the largest value
      load_denoms(3'd1, 16'hffff, 16'd2, 16'd5, 16'd10);
      send_word(OP_SET, 16'd0, 2'd0, 8'd255);
      send_word(OP_CHANGE, 16'hffff, 2'd0, 8'd0);
   endtask

   task automatic run_traffic(input int items, input int idle, input int stall);
      int sent;
      int r;
      sent = 0;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      while (sent < items) begin
         r = $urandom_range(99);
         if (r < 12) begin
            for (int s = 0; s < NUM_SLOTS; s++)
               send_word(OP_SET, AMOUNT_W'($urandom), SLOT_IN_W'(s),
                         STOCK_W'($urandom_range(0, 255)));
            sent += NUM_SLOTS;
         end else if (r < 32) begin
            send_word(OP_SET, AMOUNT_W'($urandom), SLOT_IN_W'($urandom_range(0, 3)),
                      STOCK_W'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_word(OP_CHANGE, pick_amount(), SLOT_IN_W'($urandom_range(0, 3)),
                      STOCK_W'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      load_denoms(3'd4, 16'd1, 16'd2, 16'd5, 16'd10);
      run_traffic(72, 0, 0);
      load_denoms(3'd4, 16'd1, 16'd255, 16'd4096, 16'hffff);
      run_traffic(72, 53, 0);
      load_random_denoms(1, 4);
      run_traffic(72, 0, 53);
      load_random_denoms(0, 7);
      run_traffic(72, 19, 19);
   endtask

   always @(posedge clock) begin
      payout_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (payout_q.size() == 0) begin
            $error("unexpected result word: slot_out %0d coins_used %0d",
                   rsp_tdata[1:0], rsp_tdata[9:2]);
            mismatches++;
         end else begin
            want = payout_q.pop_front();
            words_checked++;
            if (rsp_tdata[1:0] !== want.slot_out) begin
               $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_tdata[1:0]);
               mismatches++;
            end
            if (rsp_tdata[9:2] !== want.coins_used) begin
               $error("coins_used: expected %0d, got %0d", want.coins_used, rsp_tdata[9:2]);
               mismatches++;
            end
            if (rsp_tuser !== want.success) begin
               $error("success: expected %0d, got %0d", want.success, rsp_tuser);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d result words outstanding", payout_q.size());
      $display("** greedy_change_maker: FAILED **");
      $finish;
   end

   initial begin
      count_model = COUNT_RESET;
      for (int s = 0; s < CFG_SLOTS; s++) denom_model[s] = denom_reset(s);
      for (int s = 0; s < NUM_SLOTS; s++) stock_left[s] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stock();
      test_stock_extremes();
      test_count_and_values();
      test_random_traffic();
      wait_idle();
      repeat (50) @(posedge clock);
      $display("covered %0d change and %0d stock words, %0d result words checked",
               change_count, stock_count, words_checked);
      $display("across %0d denomination settings and four handshake pressure phases",
               config_count);
      if (mismatches == 0 && payout_q.size() == 0) begin
         $display("** greedy_change_maker: PASSED **");
      end else begin
         $display("** greedy_change_maker: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
